[rtl/assert_macros.svh]
// Assertion macros used by the port checker of this project.
// Self-contained; expects signals named clk and arst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled while reset is applied.
`define PEF_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
// Next-cycle implication, disabled while reset is applied.
`define PEF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`endif

[rtl/pef_pkg.sv]
// Package for the epoch folding unit: sizes, codes, state encoding and helpers.
// No dependencies; the files that use it refer to it by scoped names.
package pef_pkg;

	localparam int MAX_BINS   = 256;
	localparam int BIN_W      = $clog2(MAX_BINS);
	localparam int BCNT_W     = $clog2(MAX_BINS + 1);
	localparam int MOD_W      = BCNT_W + 1;
	localparam int MODK_W     = $clog2(MOD_W);
	localparam int SUM_W      = 48;
	localparam int CNT_W      = 40;
	localparam int MEAN_W     = 25;
	localparam int ENT_W      = SUM_W + CNT_W;
	localparam int DIV_K_W    = $clog2(SUM_W);
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 40;

	localparam logic signed [MEAN_W-1:0] S25_MAX = {1'b0, {(MEAN_W-1){1'b1}}};
	localparam logic signed [MEAN_W-1:0] S25_MIN = {1'b1, {(MEAN_W-1){1'b0}}};
	localparam logic signed [SUM_W-1:0]  S48_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0]  S48_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	localparam logic RES_PEAK  = 1'b0;
	localparam logic RES_ENTRY = 1'b1;

	typedef enum logic [1:0] {
		KIND_SAMPLE,
		KIND_FINISH,
		KIND_READ,
		KIND_NONE
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BINS,
		REG_STEP,
		REG_ALPHA,
		REG_BASE,
		REG_CLIP,
		REG_DC,
		REG_LIMIT
	} cfg_reg_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_S_LP,
		ST_S_DS,
		ST_S_DEC,
		ST_S_MEAN,
		ST_S_MUL,
		ST_S_TEST,
		ST_S_BV,
		ST_S_ACC,
		ST_S_PHASE,
		ST_F_RD,
		ST_F_WAIT,
		ST_F_DIV,
		ST_F_END,
		ST_R_MOD,
		ST_R_RD,
		ST_R_WAIT,
		ST_R_DIV,
		ST_OUT
	} state_t;

	// Saturate a sum that grew by one bit back to the stored sum width.
	function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] v);
		logic signed [SUM_W-1:0] r;
		if (v[SUM_W] != v[SUM_W-1])
			r = v[SUM_W] ? S48_MIN : S48_MAX;
		else
			r = v[SUM_W-1:0];
		return r;
	endfunction

	// Count up, sticking at all ones.
	function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] c);
		logic [CNT_W-1:0] r;
		r = (&c) ? c : c + CNT_W'(1);
		return r;
	endfunction

endpackage

[rtl/pef_if.sv]
// Handshake channels of the epoch folding unit: items, results, register writes.
// Depends on pef_pkg for the register port widths.
interface pef_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic signed [15:0] sample;
	logic [7:0]         position;
	modport source (output valid, kind, sample, position, input ready);
	modport sink (input valid, kind, sample, position, output ready);
endinterface

interface pef_result_if;
	logic               valid;
	logic               ready;
	logic               result_kind;
	logic [7:0]         out_position;
	logic signed [24:0] bin_mean;
	logic [7:0]         peak_bin;
	logic signed [24:0] min_mean;
	logic signed [24:0] max_mean;
	logic [39:0]        processed_count;
	logic [39:0]        skipped_count;
	modport source (output valid, result_kind, out_position, bin_mean, peak_bin, min_mean,
		max_mean, processed_count, skipped_count, input ready);
	modport sink (input valid, result_kind, out_position, bin_mean, peak_bin, min_mean,
		max_mean, processed_count, skipped_count, output ready);
endinterface

interface pef_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [pef_pkg::CFG_IDX_W-1:0]    index;
	logic [pef_pkg::CFG_DATA_W-1:0]   data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/pef_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module pef_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

[rtl/pef_div.sv]
// Bin mean unit: signed sum over unsigned count, one quotient bit per cycle.
// Depends on pef_pkg for widths and saturation limits.
module pef_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [pef_pkg::SUM_W-1:0]   sum,
	input  logic [pef_pkg::CNT_W-1:0]          cnt,
	output logic                               done,
	output logic signed [pef_pkg::MEAN_W-1:0]  mean
);

	localparam logic [pef_pkg::SUM_W-1:0] MAG_LIM =
		pef_pkg::SUM_W'(1) << (pef_pkg::MEAN_W - 1);

	logic                            run_q;
	logic                            fin_q;
	logic [pef_pkg::DIV_K_W-1:0]     k_q;
	logic                            neg_q;
	logic                            zero_q;
	logic [pef_pkg::SUM_W-1:0]       dvd_q;
	logic [pef_pkg::CNT_W-1:0]       dvs_q;
	logic [pef_pkg::CNT_W-1:0]       rem_q;
	logic [pef_pkg::CNT_W:0]         rs;
	logic                            ge;

	assign rs = {rem_q, dvd_q[pef_pkg::SUM_W-1]};
	assign ge = (rs >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			k_q   <= '0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				k_q   <= pef_pkg::DIV_K_W'(pef_pkg::SUM_W - 1);
			end else if (run_q) begin
				if (k_q == '0) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end else begin
					k_q <= k_q - pef_pkg::DIV_K_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q  <= sum[pef_pkg::SUM_W-1];
			zero_q <= (cnt == '0);
			dvd_q  <= sum[pef_pkg::SUM_W-1] ? pef_pkg::SUM_W'(-sum) : pef_pkg::SUM_W'(sum);
			dvs_q  <= cnt;
			rem_q  <= '0;
		end else if (run_q) begin
			rem_q <= ge ? pef_pkg::CNT_W'(rs - {1'b0, dvs_q}) : pef_pkg::CNT_W'(rs);
			dvd_q <= {dvd_q[pef_pkg::SUM_W-2:0], ge};
		end
	end

	// The quotient sits in dvd_q once the last bit is in; clip it to 25-bit signed.
	always_comb begin
		if (zero_q)
			mean = '0;
		else if (neg_q)
			mean = (dvd_q >= MAG_LIM) ? pef_pkg::S25_MIN
				: -$signed(pef_pkg::MEAN_W'(dvd_q));
		else
			mean = (dvd_q >= MAG_LIM - pef_pkg::SUM_W'(1)) ? pef_pkg::S25_MAX
				: $signed(pef_pkg::MEAN_W'(dvd_q));
	end

	assign done = fin_q;

endmodule

[rtl/pef_pole.sv]
// One-pole smoothing unit: cur + (tgt - cur) * alpha / 2^32, floored.
// Depends on pef_pkg for widths.
module pef_pole (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [pef_pkg::SUM_W-1:0] cur,
	input  logic signed [pef_pkg::SUM_W-1:0] tgt,
	input  logic [31:0]                      alpha,
	output logic                             done,
	output logic signed [pef_pkg::SUM_W-1:0] res
);

	localparam int DIFF_W = pef_pkg::SUM_W + 2;
	localparam int PROD_W = DIFF_W + 17;

	logic                              run_q;
	logic [1:0]                        step_q;
	logic                              done_q;
	logic signed [DIFF_W-1:0]          d_q;
	logic signed [pef_pkg::SUM_W-1:0]  cur_q;
	logic signed [PROD_W-1:0]          plo_q;
	logic signed [PROD_W-1:0]          phi_q;
	logic signed [pef_pkg::SUM_W-1:0]  res_q;
	logic signed [PROD_W-1:0]          total;

	assign total = phi_q + (plo_q >>> 16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd2) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Low half of the weight first, then the high half, then the final floor and add.
	always_ff @(posedge clk) begin
		if (start) begin
			d_q   <= DIFF_W'(tgt) - DIFF_W'(cur);
			cur_q <= cur;
		end else if (run_q) begin
			case (step_q)
				2'd0:    plo_q <= d_q * $signed({1'b0, alpha[15:0]});
				2'd1:    phi_q <= d_q * $signed({1'b0, alpha[31:16]});
				default: res_q <= cur_q + pef_pkg::SUM_W'(total >>> 16);
			endcase
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

[rtl/pulsar_epoch_folder_unit.sv]
// Top level of the epoch folding unit: sequencer, per-bin memory and result register.
// Depends on pef_pkg, pef_if, pef_ram, pef_div and pef_pole.
//
//   Channel   Direction  Moves                            Accepted when
//   item      in         kind, sample, position           item.valid && item.ready
//   result    out        peak report or profile entry     result.valid && result.ready
//   cfg       in         register index and write data    cfg.valid && cfg.ready
//
// A sample request runs the smoothing unit for the low-pass; while the baseline is
// gathered or clipping is off it is then accumulated, else it is tested against the
// clip level and, if kept, the smoothing unit runs again for the running mean; the
// first sample past the baseline also goes through the 48-step mean divider.
// A finish request reads, waits and divides per bin; a read request reduces its
// position, then reads, waits and divides, or goes straight out when past the last bin.
// Reset clears the sequencer and folding state and the 256 bin valid bits at once; no sweep.
// A finished result waits in the output register while the next request is taken.
module pulsar_epoch_folder_unit (
	input  logic clk,
	input  logic arst_n,
	pef_item_if.sink     item,
	pef_result_if.source result,
	pef_cfg_if.sink      cfg
);

	localparam int SUM_W  = pef_pkg::SUM_W;
	localparam int CNT_W  = pef_pkg::CNT_W;
	localparam int MEAN_W = pef_pkg::MEAN_W;
	localparam int BIN_W  = pef_pkg::BIN_W;
	localparam int BCNT_W = pef_pkg::BCNT_W;
	localparam int MOD_W  = pef_pkg::MOD_W;
	localparam int SUB_W  = MOD_W + BCNT_W;

	// Configuration registers.
	logic [8:0]         bins_q;
	logic [31:0]        step_q;
	logic [31:0]        alpha_q;
	logic [39:0]        base_q;
	logic [15:0]        clip_q;
	logic signed [23:0] dc_q;
	logic [39:0]        limit_q;

	// Folding state.
	logic signed [SUM_W-1:0] lp_q;
	logic [BIN_W-1:0]        cur_bin_q;
	logic [31:0]             phase_q;
	logic [CNT_W-1:0]        smp_cnt_q;
	logic [CNT_W-1:0]        skip_cnt_q;
	logic signed [SUM_W-1:0] bv_q;
	logic [CNT_W-1:0]        bc_q;
	logic                    bdone_q;
	logic [BIN_W-1:0]        peak_q;
	logic [pef_pkg::MAX_BINS-1:0] vld_q;

	// Per-request working registers.
	pef_pkg::state_t          state_q, state_d;
	logic signed [15:0]       s_q;
	logic signed [MEAN_W-1:0] ds_q;
	logic [63:0]              rhs_q;
	logic [BCNT_W-1:0]        idx_q;
	logic signed [MEAN_W-1:0] mn_q;
	logic signed [MEAN_W-1:0] mx_q;
	logic [BIN_W-1:0]         loc_q;
	logic                     rk_q;
	logic [7:0]               rpos_q;
	logic signed [MEAN_W-1:0] rmean_q;
	logic [MOD_W-1:0]         t_q;
	logic [pef_pkg::MODK_W-1:0] k_q;
	logic                     rd_vld_s1;

	// Result register.
	logic                     res_vld_q;
	logic                     o_kind_q;
	logic [7:0]               o_pos_q;
	logic signed [MEAN_W-1:0] o_mean_q;
	logic [7:0]               o_peak_q;
	logic signed [MEAN_W-1:0] o_min_q;
	logic signed [MEAN_W-1:0] o_max_q;
	logic [CNT_W-1:0]         o_proc_q;
	logic [CNT_W-1:0]         o_skip_q;

	// Memory, smoothing and divider hookup.
	logic                      ram_re;
	logic                      ram_we;
	logic [BIN_W-1:0]          ram_raddr;
	logic [pef_pkg::ENT_W-1:0] ram_wdata;
	logic [pef_pkg::ENT_W-1:0] ram_rdata;
	logic signed [SUM_W-1:0]   ent_sum;
	logic [CNT_W-1:0]          ent_cnt;
	logic                      pole_start;
	logic signed [SUM_W-1:0]   pole_cur;
	logic signed [SUM_W-1:0]   pole_tgt;
	logic                      pole_done;
	logic signed [SUM_W-1:0]   pole_res;
	logic                      div_start;
	logic signed [SUM_W-1:0]   div_sum;
	logic [CNT_W-1:0]          div_cnt;
	logic                      div_done;
	logic signed [MEAN_W-1:0]  div_mean;

	// Derived values.
	logic                      acc_in;
	logic                      start_smp;
	logic                      res_load;
	logic [BCNT_W-1:0]         bins_n;
	logic                      in_base;
	logic signed [33:0]        ds_raw;
	logic signed [MEAN_W-1:0]  ds_sat;
	logic [SUM_W-1:0]          bv_mag;
	logic [MEAN_W-1:0]         ds_mag;
	logic [63:0]               lhs;
	logic                      keep;
	logic [32:0]               phase_sum;
	logic [BCNT_W-1:0]         next_bin;
	logic [SUB_W-1:0]          mod_sub;
	logic [MOD_W-1:0]          rd_start;

	// Register writes; writes to an index past the list are dropped.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bins_q  <= 9'd250;
			step_q  <= 32'd107374182;
			alpha_q <= 32'd14316;
			base_q  <= 40'd6000000;
			clip_q  <= 16'd1280;
			dc_q    <= '0;
			limit_q <= '1;
		end else if (cfg.valid) begin
			unique case (pef_pkg::cfg_reg_t'(cfg.index))
				pef_pkg::REG_BINS:  bins_q  <= cfg.data[8:0];
				pef_pkg::REG_STEP:  step_q  <= cfg.data[31:0];
				pef_pkg::REG_ALPHA: alpha_q <= cfg.data[31:0];
				pef_pkg::REG_BASE:  base_q  <= cfg.data;
				pef_pkg::REG_CLIP:  clip_q  <= cfg.data[15:0];
				pef_pkg::REG_DC:    dc_q    <= $signed(cfg.data[23:0]);
				pef_pkg::REG_LIMIT: limit_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// A bin count of zero acts as one; counts past the memory depth are clipped.
	always_comb begin
		if (bins_q == '0)
			bins_n = BCNT_W'(1);
		else if (int'(bins_q) > pef_pkg::MAX_BINS)
			bins_n = BCNT_W'(pef_pkg::MAX_BINS);
		else
			bins_n = BCNT_W'(bins_q);
	end

	// Memory entries never written read as an empty bin.
	assign ent_sum = rd_vld_s1 ? $signed(ram_rdata[pef_pkg::ENT_W-1:CNT_W]) : '0;
	assign ent_cnt = rd_vld_s1 ? ram_rdata[CNT_W-1:0] : '0;

	// High-passed sample in Q.8: the raw sample less the low-pass, plus the offset.
	assign ds_raw = (34'(s_q) <<< 8) - 34'(lp_q >>> 16) + 34'(dc_q);
	always_comb begin
		if (ds_raw > 34'(pef_pkg::S25_MAX))
			ds_sat = pef_pkg::S25_MAX;
		else if (ds_raw < 34'(pef_pkg::S25_MIN))
			ds_sat = pef_pkg::S25_MIN;
		else
			ds_sat = MEAN_W'(ds_raw);
	end

	// Clip test: |ds| * 2^24 against |baseline| * threshold.
	assign in_base = !bdone_q && (smp_cnt_q <= base_q);
	assign bv_mag  = bv_q[SUM_W-1] ? SUM_W'(-bv_q) : SUM_W'(bv_q);
	assign ds_mag  = ds_q[MEAN_W-1] ? MEAN_W'(-ds_q) : MEAN_W'(ds_q);
	assign lhs     = 64'(ds_mag) << 24;
	assign keep    = lhs < rhs_q;

	assign phase_sum = {1'b0, phase_q} + {1'b0, step_q};
	assign next_bin  = BCNT_W'(cur_bin_q) + BCNT_W'(1);
	assign mod_sub   = SUB_W'(bins_n) << k_q;
	assign rd_start  = MOD_W'(peak_q) + MOD_W'(item.position)
		+ MOD_W'(bins_n - (bins_n >> 1));

	assign ram_wdata = {pef_pkg::sat_sum((SUM_W + 1)'(ent_sum) + (SUM_W + 1)'(ds_q)),
		pef_pkg::inc_sat(ent_cnt)};

	assign acc_in   = item.valid && item.ready;
	assign res_load = (state_q == pef_pkg::ST_OUT) && (!res_vld_q || result.ready);
	assign item.ready = (state_q == pef_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= pef_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// Sequencer: next state and the strobes to the memory and the arithmetic units.
	always_comb begin
		state_d    = state_q;
		start_smp  = 1'b0;
		ram_re     = 1'b0;
		ram_we     = 1'b0;
		ram_raddr  = cur_bin_q;
		pole_start = 1'b0;
		pole_cur   = lp_q;
		pole_tgt   = SUM_W'(item.sample) <<< 24;
		div_start  = 1'b0;
		div_sum    = ent_sum;
		div_cnt    = ent_cnt;
		unique case (state_q)
			pef_pkg::ST_IDLE: begin
				if (acc_in) begin
					unique case (pef_pkg::kind_t'(item.kind))
						pef_pkg::KIND_SAMPLE: begin
							// Past the sample limit a sample is dropped untouched.
							if (smp_cnt_q < limit_q) begin
								start_smp  = 1'b1;
								ram_re     = 1'b1;
								pole_start = 1'b1;
								state_d    = pef_pkg::ST_S_LP;
							end
						end
						pef_pkg::KIND_FINISH: state_d = pef_pkg::ST_F_RD;
						pef_pkg::KIND_READ: begin
							if (BCNT_W'(item.position) >= bins_n)
								state_d = pef_pkg::ST_OUT;
							else
								state_d = pef_pkg::ST_R_MOD;
						end
						pef_pkg::KIND_NONE: ;
					endcase
				end
			end
			pef_pkg::ST_S_LP: if (pole_done) state_d = pef_pkg::ST_S_DS;
			pef_pkg::ST_S_DS: state_d = pef_pkg::ST_S_DEC;
			pef_pkg::ST_S_DEC: begin
				if (in_base)
					state_d = pef_pkg::ST_S_ACC;
				else if (clip_q != '0) begin
					if (!bdone_q) begin
						// First sample after the baseline: turn the sum into its mean.
						div_start = 1'b1;
						div_sum   = bv_q;
						div_cnt   = bc_q;
						state_d   = pef_pkg::ST_S_MEAN;
					end else
						state_d = pef_pkg::ST_S_MUL;
				end else
					state_d = pef_pkg::ST_S_ACC;
			end
			pef_pkg::ST_S_MEAN: if (div_done) state_d = pef_pkg::ST_S_MUL;
			pef_pkg::ST_S_MUL: state_d = pef_pkg::ST_S_TEST;
			pef_pkg::ST_S_TEST: begin
				if (keep) begin
					pole_start = 1'b1;
					pole_cur   = bv_q;
					pole_tgt   = SUM_W'(ds_q) <<< 16;
					state_d    = pef_pkg::ST_S_BV;
				end else
					state_d = pef_pkg::ST_S_PHASE;
			end
			pef_pkg::ST_S_BV: if (pole_done) state_d = pef_pkg::ST_S_ACC;
			pef_pkg::ST_S_ACC: begin
				ram_we  = 1'b1;
				state_d = pef_pkg::ST_S_PHASE;
			end
			pef_pkg::ST_S_PHASE: state_d = pef_pkg::ST_IDLE;
			pef_pkg::ST_F_RD: begin
				ram_re    = 1'b1;
				ram_raddr = idx_q[BIN_W-1:0];
				state_d   = pef_pkg::ST_F_WAIT;
			end
			pef_pkg::ST_F_WAIT: begin
				div_start = 1'b1;
				state_d   = pef_pkg::ST_F_DIV;
			end
			pef_pkg::ST_F_DIV: begin
				if (div_done)
					state_d = (idx_q == bins_n - BCNT_W'(1)) ? pef_pkg::ST_F_END
						: pef_pkg::ST_F_RD;
			end
			pef_pkg::ST_F_END: state_d = pef_pkg::ST_OUT;
			pef_pkg::ST_R_MOD: if (k_q == '0) state_d = pef_pkg::ST_R_RD;
			pef_pkg::ST_R_RD: begin
				ram_re    = 1'b1;
				ram_raddr = t_q[BIN_W-1:0];
				state_d   = pef_pkg::ST_R_WAIT;
			end
			pef_pkg::ST_R_WAIT: begin
				div_start = 1'b1;
				state_d   = pef_pkg::ST_R_DIV;
			end
			pef_pkg::ST_R_DIV: if (div_done) state_d = pef_pkg::ST_OUT;
			pef_pkg::ST_OUT: if (res_load) state_d = pef_pkg::ST_IDLE;
			default: state_d = pef_pkg::ST_IDLE;
		endcase
	end

	// Folding state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q       <= '0;
			cur_bin_q  <= '0;
			phase_q    <= '0;
			smp_cnt_q  <= '0;
			skip_cnt_q <= '0;
			bv_q       <= '0;
			bc_q       <= '0;
			bdone_q    <= 1'b0;
			peak_q     <= '0;
			vld_q      <= '0;
		end else begin
			if (ram_we)
				vld_q[cur_bin_q] <= 1'b1;
			if (start_smp)
				smp_cnt_q <= smp_cnt_q + CNT_W'(1);
			case (state_q)
				pef_pkg::ST_S_LP: if (pole_done) lp_q <= pole_res;
				pef_pkg::ST_S_DEC: begin
					if (in_base) begin
						bv_q <= pef_pkg::sat_sum((SUM_W + 1)'(bv_q) + (SUM_W + 1)'(ds_q));
						bc_q <= pef_pkg::inc_sat(bc_q);
					end
				end
				pef_pkg::ST_S_MEAN: begin
					if (div_done) begin
						bv_q    <= SUM_W'(div_mean) <<< 16;
						bdone_q <= 1'b1;
					end
				end
				pef_pkg::ST_S_TEST: if (!keep) skip_cnt_q <= pef_pkg::inc_sat(skip_cnt_q);
				pef_pkg::ST_S_BV: if (pole_done) bv_q <= pole_res;
				pef_pkg::ST_S_PHASE: begin
					phase_q <= phase_sum[31:0];
					if (phase_sum[32])
						cur_bin_q <= (next_bin >= bins_n) ? '0 : BIN_W'(next_bin);
				end
				pef_pkg::ST_F_END: peak_q <= loc_q;
				default: ;
			endcase
		end
	end

	// Working registers of the request in progress.
	always_ff @(posedge clk) begin
		if (ram_re)
			rd_vld_s1 <= vld_q[ram_raddr];
		case (state_q)
			pef_pkg::ST_IDLE: begin
				s_q     <= item.sample;
				idx_q   <= '0;
				mn_q    <= '0;
				mx_q    <= '0;
				loc_q   <= '0;
				rmean_q <= '0;
				t_q     <= rd_start;
				k_q     <= pef_pkg::MODK_W'(MOD_W - 1);
				if (pef_pkg::kind_t'(item.kind) == pef_pkg::KIND_READ) begin
					rk_q   <= pef_pkg::RES_ENTRY;
					rpos_q <= item.position;
				end else begin
					rk_q   <= pef_pkg::RES_PEAK;
					rpos_q <= '0;
				end
			end
			pef_pkg::ST_S_DS: ds_q <= ds_sat;
			pef_pkg::ST_S_MUL: rhs_q <= bv_mag * clip_q;
			pef_pkg::ST_F_DIV: begin
				if (div_done) begin
					if (idx_q == '0 || div_mean < mn_q)
						mn_q <= div_mean;
					if (div_mean > mx_q) begin
						mx_q  <= div_mean;
						loc_q <= idx_q[BIN_W-1:0];
					end
					idx_q <= idx_q + BCNT_W'(1);
				end
			end
			// Read position to bin: reduce modulo n by shifted subtracts.
			pef_pkg::ST_R_MOD: begin
				if (SUB_W'(t_q) >= mod_sub)
					t_q <= t_q - MOD_W'(mod_sub);
				k_q <= k_q - pef_pkg::MODK_W'(1);
			end
			pef_pkg::ST_R_DIV: if (div_done) rmean_q <= div_mean;
			default: ;
		endcase
	end

	// Output register; it frees the sequencer while the result waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_vld_q <= 1'b0;
		else if (res_load)
			res_vld_q <= 1'b1;
		else if (result.ready)
			res_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			o_kind_q <= rk_q;
			o_pos_q  <= rpos_q;
			o_mean_q <= rmean_q;
			o_peak_q <= 8'(peak_q);
			o_min_q  <= mn_q;
			o_max_q  <= mx_q;
			o_proc_q <= smp_cnt_q;
			o_skip_q <= skip_cnt_q;
		end
	end

	assign result.valid           = res_vld_q;
	assign result.result_kind     = o_kind_q;
	assign result.out_position    = o_pos_q;
	assign result.bin_mean        = o_mean_q;
	assign result.peak_bin        = o_peak_q;
	assign result.min_mean        = o_min_q;
	assign result.max_mean        = o_max_q;
	assign result.processed_count = o_proc_q;
	assign result.skipped_count   = o_skip_q;

	// Bin sums and counts share one memory word per bin.
	pef_ram #(
		.WIDTH (pef_pkg::ENT_W),
		.DEPTH (pef_pkg::MAX_BINS)
	) u_bins (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cur_bin_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	pef_pole u_pole (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (pole_start),
		.cur    (pole_cur),
		.tgt    (pole_tgt),
		.alpha  (alpha_q),
		.done   (pole_done),
		.res    (pole_res)
	);

	pef_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.sum    (div_sum),
		.cnt    (div_cnt),
		.done   (div_done),
		.mean   (div_mean)
	);

endmodule

[rtl/pef_checker.sv]
// Port-level checks of the epoch folding unit, bound to its top level.
// Depends on assert_macros.svh and pef_pkg.
`include "assert_macros.svh"

module pef_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_ready,
	input logic               res_kind,
	input logic [7:0]         out_position,
	input logic signed [24:0] bin_mean,
	input logic signed [24:0] min_mean,
	input logic signed [24:0] max_mean,
	input logic [39:0]        processed_count,
	input logic [39:0]        skipped_count
);

	// A waiting result stays offered.
	`PEF_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid)
	// A peak report has no position or entry mean, and its maximum is never negative.
	`PEF_ASSERT_IMPL(a_peak_form, res_valid && (res_kind == pef_pkg::RES_PEAK), (out_position == 8'd0) && (bin_mean == '0) && !max_mean[24])
	// A profile entry carries no scan extremes.
	`PEF_ASSERT_IMPL(a_entry_form, res_valid && (res_kind == pef_pkg::RES_ENTRY), (min_mean == '0) && (max_mean == '0))
	// Only taken samples can be skipped.
	`PEF_ASSERT_IMPL(a_skip_bound, res_valid, skipped_count <= processed_count)

endmodule

bind pulsar_epoch_folder_unit pef_checker u_pef_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.res_valid       (result.valid),
	.res_ready       (result.ready),
	.res_kind        (result.result_kind),
	.out_position    (result.out_position),
	.bin_mean        (result.bin_mean),
	.min_mean        (result.min_mean),
	.max_mean        (result.max_mean),
	.processed_count (result.processed_count),
	.skipped_count   (result.skipped_count)
);

[test/pulsar_epoch_folder_unit_checker.sv]
// Checker for the epoch folding unit: watches the item, result and register channels,
// predicts every result and compares it. Depends on pef_pkg and the pef_if interfaces.
module pulsar_epoch_folder_unit_checker (
	input  logic  clk,
	input  logic  arst_n,
	pef_item_if   item,
	pef_result_if result,
	pef_cfg_if    cfg,
	output int    fail_count,
	output int    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint unsigned CNT_MAX = 64'hFF_FFFF_FFFF;
	localparam longint SUM_HI  = 64'sh7FFF_FFFF_FFFF;
	localparam longint SUM_LO  = -SUM_HI - 1;
	localparam longint MEAN_HI = 64'sh00FF_FFFF;
	localparam longint MEAN_LO = -MEAN_HI - 1;

	typedef struct {
		logic                              res_kind;
		logic [7:0]                        pos;
		logic signed [pef_pkg::MEAN_W-1:0] mean;
		logic [7:0]                        peak;
		logic signed [pef_pkg::MEAN_W-1:0] mn;
		logic signed [pef_pkg::MEAN_W-1:0] mx;
		logic [pef_pkg::CNT_W-1:0]         taken;
		logic [pef_pkg::CNT_W-1:0]         dropped;
	} profile_result_t;

	profile_result_t expected_results[$];

	// Register copy.
	logic [8:0]                n_bins;
	logic [31:0]               step;
	logic [31:0]               alpha;
	logic [pef_pkg::CNT_W-1:0] base_len;
	logic [15:0]               clip;
	longint                    offset;
	logic [pef_pkg::CNT_W-1:0] limit;

	// Folding state.
	longint           lp;
	longint           sums[pef_pkg::MAX_BINS];
	longint unsigned  cnts[pef_pkg::MAX_BINS];
	int unsigned      cur_bin;
	logic [31:0]      frac;
	longint unsigned  n_taken, n_dropped;
	longint           base_val;
	longint unsigned  base_cnt;
	bit               base_done;
	int unsigned      peak_loc;

	function automatic longint clampl(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// First-order smoothing step with an unsigned weight over 2^32.
	function automatic longint smooth(longint c, longint target, logic [31:0] a);
		longint d, hi, lo;
		d  = target - c;
		hi = d * longint'({32'b0, a[31:16]});
		lo = (d * longint'({48'b0, a[15:0]})) >>> 16;
		return c + ((hi + lo) >>> 16);
	endfunction

	function automatic longint mean_of(longint s, longint unsigned c);
		longint unsigned q;
		longint m;
		if (c == 0)
			return 0;
		q = (s < 0 ? longint'(-s) : s) / c;
		if (q > 64'h100_0000)
			q = 64'h100_0000;
		m = s < 0 ? -longint'(q) : longint'(q);
		return clampl(m, MEAN_LO, MEAN_HI);
	endfunction

	function automatic int unsigned active_bins();
		if (n_bins < 1)
			return 1;
		if (n_bins > pef_pkg::MAX_BINS)
			return pef_pkg::MAX_BINS;
		return 32'(n_bins);
	endfunction

	function automatic void add_to_bin(longint ds);
		sums[cur_bin] = clampl(sums[cur_bin] + ds, SUM_LO, SUM_HI);
		if (cnts[cur_bin] < CNT_MAX)
			cnts[cur_bin]++;
	endfunction

	function automatic void fold_sample(longint s);
		longint ds;
		longint unsigned lhs, rhs;
		logic [32:0] nxt;
		if (n_taken >= limit)
			return;
		n_taken++;
		lp = smooth(lp, s * 64'sd16777216, alpha);
		ds = clampl(s * 256 - (lp >>> 16) + offset, MEAN_LO, MEAN_HI);
		if (!base_done && n_taken <= base_len) begin
			add_to_bin(ds);
			base_val = clampl(base_val + ds, SUM_LO, SUM_HI);
			if (base_cnt < CNT_MAX)
				base_cnt++;
		end else if (clip != 0) begin
			// The first sample past the baseline period turns the sum into a mean.
			if (!base_done) begin
				base_val  = mean_of(base_val, base_cnt) * 65536;
				base_done = 1;
			end
			lhs = longint'(ds < 0 ? -ds : ds) << 24;
			rhs = longint'(base_val < 0 ? -base_val : base_val) * longint'({48'b0, clip});
			if (lhs < rhs) begin
				add_to_bin(ds);
				base_val = smooth(base_val, ds * 65536, alpha);
			end else if (n_dropped < CNT_MAX) begin
				n_dropped++;
			end
		end else begin
			add_to_bin(ds);
		end
		nxt  = {1'b0, frac} + {1'b0, step};
		frac = nxt[31:0];
		if (nxt[32]) begin
			cur_bin++;
			if (cur_bin >= active_bins())
				cur_bin = 0;
		end
	endfunction

	function automatic void clear_model();
		n_bins = 9'd250; step = 32'd107374182; alpha = 32'd14316; base_len = 40'd6000000;
		clip = 16'd1280; offset = 0; limit = 40'(CNT_MAX);
		lp = 0; cur_bin = 0; frac = '0; n_taken = 0; n_dropped = 0;
		base_val = 0; base_cnt = 0; base_done = 0; peak_loc = 0;
		foreach (sums[i]) begin
			sums[i] = 0;
			cnts[i] = 0;
		end
	endfunction

	function automatic void predict(pef_pkg::kind_t k, longint s, int unsigned p);
		profile_result_t r;
		int unsigned n, b;
		longint m, mn, mx;
		n = active_bins();
		r.taken = 40'(n_taken);
		r.dropped = 40'(n_dropped);
		case (k)
			pef_pkg::KIND_SAMPLE: fold_sample(s);
			pef_pkg::KIND_FINISH: begin
				mn = 0; mx = 0; b = 0;
				for (int unsigned i = 0; i < n; i++) begin
					m = mean_of(sums[i], cnts[i]);
					if (i == 0 || m < mn)
						mn = m;
					if (m > mx) begin
						mx = m;
						b = i;
					end
				end
				peak_loc = b;
				r.res_kind = pef_pkg::RES_PEAK; r.pos = '0; r.mean = '0;
				r.peak = 8'(b); r.mn = 25'(mn); r.mx = 25'(mx);
				expected_results.push_back(r);
			end
			pef_pkg::KIND_READ: begin
				m = 0;
				if (p < n) begin
					b = (peak_loc + p + n - n / 2) % n;
					m = mean_of(sums[b], cnts[b]);
				end
				r.res_kind = pef_pkg::RES_ENTRY; r.pos = 8'(p); r.mean = 25'(m);
				r.peak = 8'(peak_loc); r.mn = '0; r.mx = '0;
				expected_results.push_back(r);
			end
			default: ;
		endcase
	endfunction

	function automatic void compare_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s expected %0h actual %0h", $realtime, name, exp_v, got_v);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		profile_result_t e;
		if (!arst_n) begin
			clear_model();
			expected_results.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// Results leave before a new request is folded in at the same edge.
			if (result.valid && result.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result with nothing expected, kind %0d", $realtime,
						result.result_kind);
					fail_count++;
				end else begin
					e = expected_results.pop_front();
					compare_field("result_kind", 64'(e.res_kind), 64'(result.result_kind));
					compare_field("out_position", 64'(e.pos), 64'(result.out_position));
					compare_field("bin_mean", 64'(e.mean), 64'(result.bin_mean));
					compare_field("peak_bin", 64'(e.peak), 64'(result.peak_bin));
					compare_field("min_mean", 64'(e.mn), 64'(result.min_mean));
					compare_field("max_mean", 64'(e.mx), 64'(result.max_mean));
					compare_field("processed_count", 64'(e.taken),
						64'(result.processed_count));
					compare_field("skipped_count", 64'(e.dropped), 64'(result.skipped_count));
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (pef_pkg::cfg_reg_t'(cfg.index))
					pef_pkg::REG_BINS:  n_bins = cfg.data[8:0];
					pef_pkg::REG_STEP:  step = cfg.data[31:0];
					pef_pkg::REG_ALPHA: alpha = cfg.data[31:0];
					pef_pkg::REG_BASE:  base_len = cfg.data;
					pef_pkg::REG_CLIP:  clip = cfg.data[15:0];
					pef_pkg::REG_DC:    offset = longint'($signed(cfg.data[23:0]));
					pef_pkg::REG_LIMIT: limit = cfg.data;
					default: ;
				endcase
			end
			if (item.valid && item.ready)
				predict(pef_pkg::kind_t'(item.kind), longint'(item.sample),
					32'(item.position));
			pending = expected_results.size();
		end
	end
endmodule

[test/pulsar_epoch_folder_unit_tb.sv]
// Testbench top for the epoch folding unit: clock, reset, request stimulus and verdict.
// Depends on pef_pkg, pef_if, the unit itself and pulsar_epoch_folder_unit_checker.
module pulsar_epoch_folder_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   pending;

	// Percent of requests the sender delays with a gap, and of cycles in which the receiver sits idle.
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	// Cycles the receiver still has to hold off; counted down by its own process.
	int   recv_hold = 0;

	pef_item_if   item ();
	pef_result_if result ();
	pef_cfg_if    cfg ();

	pulsar_epoch_folder_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result),
		.cfg    (cfg)
	);

	pulsar_epoch_folder_unit_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.result     (result),
		.cfg        (cfg),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	initial begin
		item.valid = 1'b0;
		item.kind = pef_pkg::KIND_SAMPLE;
		item.sample = '0;
		item.position = '0;
		cfg.valid = 1'b0;
		cfg.index = pef_pkg::REG_BINS;
		cfg.data = '0;
		result.ready = 1'b0;
	end

	// Receiver: a long hold-off wins over the random stalls.
	initial begin
		forever begin
			@(negedge clk);
			if (recv_hold > 0) begin
				result.ready <= 1'b0;
				recv_hold = recv_hold - 1;
			end else begin
				result.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Offer one request; gaps before it follow the sender's idle rate. The valid
	// line is touched once per falling edge, so back-to-back requests stay high.
	task automatic send_request(pef_pkg::kind_t k, logic [15:0] s, logic [7:0] p);
		int gap;
		gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
		repeat (gap) begin
			@(negedge clk);
			item.valid <= 1'b0;
		end
		@(negedge clk);
		item.valid <= 1'b1;
		item.kind <= k;
		item.sample <= s;
		item.position <= p;
		do
			@(posedge clk);
		while (!item.ready);
	endtask

	task automatic write_reg(pef_pkg::cfg_reg_t r, logic [pef_pkg::CFG_DATA_W-1:0] v);
		@(negedge clk);
		item.valid <= 1'b0;
		cfg.valid <= 1'b1;
		cfg.index <= r;
		cfg.data <= v;
		do
			@(posedge clk);
		while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// Wait for every expected result, then for the unit to come back to idle so
	// that trailing sample requests finish before the registers change.
	task automatic drain();
		@(negedge clk);
		item.valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		while (!item.ready)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic set_all(logic [8:0] nb, logic [31:0] st, logic [31:0] al,
		logic [39:0] bl, logic [15:0] cl, logic [23:0] dc, logic [39:0] lim);
		write_reg(pef_pkg::REG_BINS, pef_pkg::CFG_DATA_W'(nb));
		write_reg(pef_pkg::REG_STEP, pef_pkg::CFG_DATA_W'(st));
		write_reg(pef_pkg::REG_ALPHA, pef_pkg::CFG_DATA_W'(al));
		write_reg(pef_pkg::REG_BASE, bl);
		write_reg(pef_pkg::REG_CLIP, pef_pkg::CFG_DATA_W'(cl));
		write_reg(pef_pkg::REG_DC, pef_pkg::CFG_DATA_W'(dc));
		write_reg(pef_pkg::REG_LIMIT, lim);
	endtask

	// Mostly quiet signal with scattered full-scale noise and the rails.
	function automatic logic [15:0] pick_sample();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return 16'($signed($urandom_range(1000)) - 500);
		if (r < 90)
			return 16'($urandom);
		return ($urandom_range(1) != 0) ? 16'h7FFF : 16'h8000;
	endfunction

	function automatic logic [8:0] pick_bins();
		int r;
		r = $urandom_range(99);
		if (r < 80)
			return 9'($urandom_range(1, 16));
		if (r < 88)
			return 9'd256;
		if (r < 94)
			return 9'd0;
		return 9'($urandom_range(257, 511));
	endfunction

	function automatic logic [31:0] pick_step();
		int r;
		r = $urandom_range(3);
		if (r == 0)
			return 32'hFFFF_FFFF;
		if (r == 1)
			return 32'h0;
		return $urandom;
	endfunction

	initial begin
		int n_req, r;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: the reset settings first, a finish over all 250 bins, then
		// full-scale samples and the rails.
		send_request(pef_pkg::KIND_SAMPLE, 16'h7FFF, 8'd0);
		send_request(pef_pkg::KIND_FINISH, 16'h0, 8'd0);
		send_request(pef_pkg::KIND_READ, 16'h0, 8'd249);
		send_request(pef_pkg::KIND_READ, 16'h0, 8'd250);
		drain();
		set_all(9'd4, 32'h8000_0000, 32'hFFFF_FFFF, 40'd3, 16'hFFFF, 24'h7FFFFF,
			40'hFF_FFFF_FFFF);
		send_request(pef_pkg::KIND_SAMPLE, 16'h7FFF, 8'h0);
		send_request(pef_pkg::KIND_SAMPLE, 16'h8000, 8'h0);
		send_request(pef_pkg::KIND_SAMPLE, 16'h0001, 8'h0);
		send_request(pef_pkg::KIND_SAMPLE, 16'hFFFF, 8'h0);
		send_request(pef_pkg::KIND_SAMPLE, 16'h0000, 8'h0);
		send_request(pef_pkg::KIND_NONE, 16'hFFFF, 8'hFF);
		send_request(pef_pkg::KIND_FINISH, 16'h0, 8'h0);
		send_request(pef_pkg::KIND_READ, 16'h0, 8'd1);
		send_request(pef_pkg::KIND_READ, 16'h0, 8'd3);
		send_request(pef_pkg::KIND_READ, 16'h0, 8'hFF);
		drain();
		// An empty baseline with clipping on; the sample limit of three is already passed,
		// so every sample is dropped untouched. One bin and the most negative offset.
		set_all(9'd0, 32'h0, 32'h0, 40'd0, 16'd256, 24'h800000, 40'd3);
		send_request(pef_pkg::KIND_SAMPLE, 16'h1234, 8'h0);
		send_request(pef_pkg::KIND_SAMPLE, 16'h8000, 8'h0);
		send_request(pef_pkg::KIND_SAMPLE, 16'h7FFF, 8'h0);
		send_request(pef_pkg::KIND_SAMPLE, 16'h7FFF, 8'h0);
		send_request(pef_pkg::KIND_FINISH, 16'h0, 8'h0);
		send_request(pef_pkg::KIND_READ, 16'h0, 8'd0);
		drain();
		// Bin count above the maximum; the register's zero limit stops every sample.
		set_all(9'd511, 32'hFFFF_FFFF, 32'h0000_0001, 40'hFF_FFFF_FFFF, 16'h0, 24'h0, 40'h0);
		send_request(pef_pkg::KIND_SAMPLE, 16'h5555, 8'h0);
		send_request(pef_pkg::KIND_FINISH, 16'h0, 8'h0);
		send_request(pef_pkg::KIND_READ, 16'h0, 8'd128);
		drain();

		// Random phases: each is a fresh setting, a run of samples with reads and
		// finishes and no-op requests mixed in, and a closing finish with a run of reads.
		for (int ph = 0; ph < 12; ph++) begin
			send_idle_pct = (ph < 4) ? 25 : ((ph < 8) ? 69 : 0);
			recv_idle_pct = (ph < 4) ? 69 : ((ph < 8) ? 25 : 0);
			set_all(pick_bins(), pick_step(), ($urandom_range(1) != 0) ? $urandom : 32'h0,
				40'($urandom_range(40)), 16'($urandom_range(2) == 0 ? 0 : $urandom),
				24'($urandom), (ph % 3 == 2) ? 40'($urandom_range(30, 90)) : 40'hFF_FFFF_FFFF);
			if (ph == 1) begin
				// Long receiver hold-off while requests keep coming.
				recv_hold = 400;
				repeat (6) send_request(pef_pkg::KIND_READ, 16'($urandom), 8'($urandom));
			end
			n_req = $urandom_range(60, 80);
			for (int i = 0; i < n_req; i++) begin
				r = $urandom_range(99);
				if (ph == 5 && i == n_req / 2)
					drain();
				if (r < 84)
					send_request(pef_pkg::KIND_SAMPLE, pick_sample(), 8'($urandom));
				else if (r < 95)
					send_request(pef_pkg::KIND_READ, 16'($urandom), 8'($urandom));
				else if (r < 97)
					send_request(pef_pkg::KIND_FINISH, 16'($urandom), 8'($urandom));
				else
					send_request(pef_pkg::KIND_NONE, 16'($urandom), 8'($urandom));
			end
			send_request(pef_pkg::KIND_FINISH, 16'h0, 8'h0);
			repeat ($urandom_range(4, 12))
				send_request(pef_pkg::KIND_READ, 16'h0, 8'($urandom_range(20)));
			drain();
		end

		@(negedge clk);
		item.valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Run limit, far beyond the slowest correct run.
	initial begin
		#40ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

[files.f]
+incdir+rtl
rtl/pef_pkg.sv
rtl/pef_if.sv
rtl/pef_ram.sv
rtl/pef_div.sv
rtl/pef_pole.sv
rtl/pulsar_epoch_folder_unit.sv
rtl/pef_checker.sv
test/pulsar_epoch_folder_unit_checker.sv
test/pulsar_epoch_folder_unit_tb.sv
